### rtl/core/scpr_pkg.sv
// Package for the second-chance page replacement unit.
// Holds sizes, field widths, index and page types, the frame command and status structs,
// and the field conversion functions. No dependencies.
`default_nettype none

package scpr_pkg;

  localparam int unsigned FRAMES     = 8;
  localparam int unsigned PAGE_BITS  = 16;
  localparam int unsigned FRAME_W    = $clog2(FRAMES);

  localparam int unsigned PAGE_NUM_W = 16;
  localparam int unsigned USED_W     = 3;
  localparam int unsigned REFS_W     = 8;

  typedef logic [FRAME_W-1:0]    frame_idx_t;
  typedef logic [PAGE_BITS-1:0]  page_t;
  typedef logic [PAGE_NUM_W-1:0] page_num_t;
  typedef logic [USED_W-1:0]     used_t;
  typedef logic [REFS_W-1:0]     refs_t;
  typedef logic [FRAMES-1:0]     ref_vec_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOOKUP,
    ST_SWEEP,
    ST_DONE
  } seq_state_e;

  typedef struct packed {
    logic       set_hit;
    frame_idx_t hit_idx;
    logic       clear_hand;
    logic       fill_hand;
    page_t      page;
  } frm_cmd_t;

  typedef struct packed {
    logic       hit;
    frame_idx_t hit_idx;
    logic       hand_ref;
    frame_idx_t hand;
    page_t      hand_page;
    ref_vec_t   refs;
  } frm_stat_t;

  function automatic page_t to_page(page_num_t num);
    page_t p;
    p = '0;
    for (int unsigned i = 0; i < PAGE_BITS; i++) begin
      if (i < PAGE_NUM_W) p[i] = num[i];
    end
    return p;
  endfunction

  function automatic page_num_t to_page_num(page_t p);
    page_num_t num;
    num = '0;
    for (int unsigned i = 0; i < PAGE_NUM_W; i++) begin
      if (i < PAGE_BITS) num[i] = p[i];
    end
    return num;
  endfunction

  function automatic used_t to_used(frame_idx_t idx);
    used_t u;
    u = '0;
    for (int unsigned i = 0; i < USED_W; i++) begin
      if (i < FRAME_W) u[i] = idx[i];
    end
    return u;
  endfunction

  function automatic refs_t to_refs(ref_vec_t v);
    refs_t r;
    r = '0;
    for (int unsigned i = 0; i < REFS_W; i++) begin
      if (i < FRAMES) r[i] = v[i];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

### rtl/core/scpr_if.sv
// Valid/ready channel interfaces for page accesses and replacement results.
// Depends on scpr_pkg.
`default_nettype none

interface scpr_req_if;
  logic                 valid;
  logic                 ready;
  scpr_pkg::page_num_t  page_number;

  modport source (output valid, output page_number, input ready);
  modport sink   (input valid, input page_number, output ready);
endinterface

interface scpr_rsp_if;
  logic                 valid;
  logic                 ready;
  logic                 fault;
  scpr_pkg::used_t      frame_used;
  scpr_pkg::page_num_t  evicted_page;
  scpr_pkg::refs_t      reference_bits;

  modport source (output valid, output fault, output frame_used, output evicted_page,
                  output reference_bits, input ready);
  modport sink   (input valid, input fault, input frame_used, input evicted_page,
                  input reference_bits, output ready);
endinterface

`default_nettype wire

### rtl/core/scpr_frames.sv
// Frame store: page per frame, reference bits, clock hand, parallel hit match
// and the single-frame step at the hand. Depends on scpr_pkg.
`default_nettype none

module scpr_frames (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  scpr_pkg::frm_cmd_t  cmd_i,
  output scpr_pkg::frm_stat_t stat_o
);
  import scpr_pkg::*;

  page_t      pages_q [FRAMES];
  page_t      pages_d [FRAMES];
  ref_vec_t   refs_q, refs_d;
  frame_idx_t hand_q, hand_d;
  frame_idx_t hand_next;

  always_comb begin
    stat_o.hit     = 1'b0;
    stat_o.hit_idx = '0;
    for (int i = FRAMES - 1; i >= 0; i--) begin
      if (pages_q[i] == cmd_i.page) begin
        stat_o.hit     = 1'b1;
        stat_o.hit_idx = frame_idx_t'(i);
      end
    end
    stat_o.hand_ref  = refs_q[hand_q];
    stat_o.hand      = hand_q;
    stat_o.hand_page = pages_q[hand_q];
    stat_o.refs      = refs_q;
  end

  assign hand_next = (hand_q == frame_idx_t'(FRAMES - 1)) ? '0 : hand_q + 1'b1;

  always_comb begin
    pages_d = pages_q;
    refs_d  = refs_q;
    hand_d  = hand_q;
    if (cmd_i.set_hit) begin
      refs_d[cmd_i.hit_idx] = 1'b1;
    end else if (cmd_i.clear_hand) begin
      refs_d[hand_q] = 1'b0;
      hand_d         = hand_next;
    end else if (cmd_i.fill_hand) begin
      refs_d[hand_q]  = 1'b1;
      pages_d[hand_q] = cmd_i.page;
      hand_d          = hand_next;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < FRAMES; i++) begin
        pages_q[i] <= page_t'(i + 1);
      end
      refs_q <= '1;
      hand_q <= '0;
    end else begin
      pages_q <= pages_d;
      refs_q  <= refs_d;
      hand_q  <= hand_d;
    end
  end

endmodule

`default_nettype wire

### rtl/core/scpr_seq.sv
// Sequencer: takes one access, runs the lookup and the clock sweep one frame per cycle,
// and holds the result in the output register. Depends on scpr_pkg and scpr_if.
`default_nettype none

module scpr_seq (
  input  logic                clk_i,
  input  logic                rst_ni,
  scpr_req_if.sink            req_i,
  scpr_rsp_if.source          rsp_o,
  output scpr_pkg::frm_cmd_t  cmd_o,
  input  scpr_pkg::frm_stat_t stat_i
);
  import scpr_pkg::*;

  seq_state_e state_q, state_d;
  page_t      page_q, page_d;
  logic       res_fault_q, res_fault_d;
  frame_idx_t res_used_q, res_used_d;
  page_t      res_evict_q, res_evict_d;
  logic       out_valid_q, out_valid_d;
  logic       out_fault_q, out_fault_d;
  used_t      out_used_q, out_used_d;
  page_num_t  out_evict_q, out_evict_d;
  refs_t      out_refs_q, out_refs_d;
  logic       in_take;
  logic       out_free;

  assign in_take  = req_i.valid && req_i.ready;
  assign out_free = !out_valid_q || rsp_o.ready;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:   if (req_i.valid) state_d = ST_LOOKUP;
      ST_LOOKUP: state_d = stat_i.hit ? ST_DONE : ST_SWEEP;
      ST_SWEEP:  if (!stat_i.hand_ref) state_d = ST_DONE;
      ST_DONE:   if (out_free) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    req_i.ready = 1'b0;
    cmd_o       = '0;
    cmd_o.page  = page_q;
    unique case (state_q)
      ST_IDLE: req_i.ready = 1'b1;
      ST_LOOKUP: begin
        cmd_o.set_hit = stat_i.hit;
        cmd_o.hit_idx = stat_i.hit_idx;
      end
      ST_SWEEP: begin
        cmd_o.clear_hand = stat_i.hand_ref;
        cmd_o.fill_hand  = !stat_i.hand_ref;
      end
      ST_DONE: ;
      default: ;
    endcase
  end

  always_comb begin
    page_d      = page_q;
    res_fault_d = res_fault_q;
    res_used_d  = res_used_q;
    res_evict_d = res_evict_q;
    out_valid_d = out_valid_q;
    out_fault_d = out_fault_q;
    out_used_d  = out_used_q;
    out_evict_d = out_evict_q;
    out_refs_d  = out_refs_q;
    if (in_take) page_d = to_page(req_i.page_number);
    if (state_q == ST_LOOKUP && stat_i.hit) begin
      res_fault_d = 1'b0;
      res_used_d  = stat_i.hit_idx;
      res_evict_d = '0;
    end
    if (state_q == ST_SWEEP && !stat_i.hand_ref) begin
      res_fault_d = 1'b1;
      res_used_d  = stat_i.hand;
      res_evict_d = stat_i.hand_page;
    end
    if (rsp_o.valid && rsp_o.ready) out_valid_d = 1'b0;
    if (state_q == ST_DONE && out_free) begin
      out_valid_d = 1'b1;
      out_fault_d = res_fault_q;
      out_used_d  = to_used(res_used_q);
      out_evict_d = to_page_num(res_evict_q);
      out_refs_d  = to_refs(stat_i.refs);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    page_q      <= page_d;
    res_fault_q <= res_fault_d;
    res_used_q  <= res_used_d;
    res_evict_q <= res_evict_d;
    out_fault_q <= out_fault_d;
    out_used_q  <= out_used_d;
    out_evict_q <= out_evict_d;
    out_refs_q  <= out_refs_d;
  end

  assign rsp_o.valid          = out_valid_q;
  assign rsp_o.fault          = out_fault_q;
  assign rsp_o.frame_used     = out_used_q;
  assign rsp_o.evicted_page   = out_evict_q;
  assign rsp_o.reference_bits = out_refs_q;

endmodule

`default_nettype wire

### rtl/core/second_chance_page_replacement_unit.sv
// Second-chance (clock) page replacement over eight frames, one access per transaction.
// After a parallel lookup, a hit goes straight to the result; on a fault the clock sweep steps
// one frame per cycle at the hand, clearing set reference bits until it meets a clear one
// (at most FRAMES clears, then the refill).
// The block takes no new access until the current result is in the output register;
// the next access may be accepted while that result still waits to be taken.
// Depends on scpr_pkg, scpr_if, scpr_frames and scpr_seq.
`default_nettype none

module second_chance_page_replacement_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  scpr_req_if.sink    req_i,
  scpr_rsp_if.source  rsp_o
);
  import scpr_pkg::*;

  frm_cmd_t  cmd;
  frm_stat_t stat;

  scpr_seq u_seq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_i),
    .rsp_o  (rsp_o),
    .cmd_o  (cmd),
    .stat_i (stat)
  );

  scpr_frames u_frames (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd),
    .stat_o (stat)
  );

endmodule

`default_nettype wire

### rtl/core/scpr_checker.sv
// Port-level checks for the page replacement unit, and the bind that attaches them.
// Depends on scpr_pkg and second_chance_page_replacement_unit.
`default_nettype none

module scpr_checker (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_ready_i,
  input  logic                out_valid_i,
  input  logic                out_ready_i,
  input  logic                fault_i,
  input  scpr_pkg::used_t     frame_used_i,
  input  scpr_pkg::page_num_t evicted_page_i,
  input  scpr_pkg::refs_t     reference_bits_i
);
  import scpr_pkg::*;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(fault_i) &&
      $stable(frame_used_i) && $stable(evicted_page_i) && $stable(reference_bits_i))
    else $error("result changed while stalled");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("new access taken while a transaction is in progress");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !fault_i |-> evicted_page_i == '0)
    else $error("hit reports an evicted page");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> reference_bits_i[frame_used_i])
    else $error("used frame has its reference bit clear");

endmodule

bind second_chance_page_replacement_unit scpr_checker u_scpr_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_valid_i       (req_i.valid),
  .in_ready_i       (req_i.ready),
  .out_valid_i      (rsp_o.valid),
  .out_ready_i      (rsp_o.ready),
  .fault_i          (rsp_o.fault),
  .frame_used_i     (rsp_o.frame_used),
  .evicted_page_i   (rsp_o.evicted_page),
  .reference_bits_i (rsp_o.reference_bits)
);

`default_nettype wire
